>>> hdl/pbr_pkg.sv
// Shared types and constants for the priority button rule resolver.
package pbr_pkg;

  localparam int NUM_RULES_DEF = 8;
  localparam int IDX_W         = 3;
  localparam int MASK_W        = 16;
  localparam int PRIO_W        = 8;
  localparam int COORD_W       = 8;
  localparam int FORM_W        = 2;
  localparam int KEY_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int IN_DATA_W     = 96;
  localparam int OUT_DATA_W    = 56;

  typedef enum logic [2:0] {
    ST_RESOLVED,
    ST_NO_MATCH,
    ST_AMBIGUOUS,
    ST_BAD_OUTPUTS,
    ST_BAD_POLICY,
    ST_BAD_KEY,
    ST_BAD_FORM
  } status_t;

  localparam logic [FORM_W-1:0] FORM_FIXED = 2'd0;
  localparam logic [FORM_W-1:0] FORM_DIR   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_EN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_L    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_N    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_R    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_L   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_N   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_R   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KNOWN_MASK  = 3'd7;

  typedef struct packed {
    logic [MASK_W-1:0]  outs;
    logic [FORM_W-1:0]  form;
    logic [MASK_W-1:0]  fixed_xy;
    logic               needs_dir;
    logic [COORD_W-1:0] forced_y;
  } action_t;

  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [IDX_W-1:0]   index;
    logic               en;
    logic [MASK_W-1:0]  trig;
    logic [PRIO_W-1:0]  prio;
    action_t            wr_act;
    logic [MASK_W-1:0]  buttons;
    logic [KEY_W-1:0]   key;
    logic               found;
    logic               amb;
    logic [PRIO_W-1:0]  best;
    logic [IDX_W-1:0]   sel;
    action_t            win_act;
  } token_t;

  typedef struct packed {
    logic               custom_en;
    logic [COORD_W-1:0] custom_l;
    logic [COORD_W-1:0] custom_n;
    logic [COORD_W-1:0] custom_r;
    logic [COORD_W-1:0] default_l;
    logic [COORD_W-1:0] default_n;
    logic [COORD_W-1:0] default_r;
    logic [MASK_W-1:0]  known_mask;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  detail;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
    logic [MASK_W-1:0]  bits;
    logic [IDX_W-1:0]   sel;
    logic               matched;
    status_t            status;
  } result_t;

endpackage

>>> hdl/pbr_cell.sv
// One rule cell: stores a rule and updates the passing transaction's best match.
module pbr_cell
  import pbr_pkg::*;
#(
  parameter int CellIdx = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   advance,
  input  token_t tok_in,
  output token_t tok_out
);

  logic              en_r;
  logic [MASK_W-1:0] trig_r;
  logic [PRIO_W-1:0] prio_r;
  action_t           act_r;
  logic              valid_r;
  token_t            data_r;
  token_t            tok_nxt;
  logic              hit;
  logic              fire;

  assign hit = tok_in.valid && tok_in.wr && (int'(tok_in.index) == CellIdx);

  always_comb begin
    tok_nxt = tok_in;
    fire    = tok_in.valid && !tok_in.wr && en_r && (trig_r != '0) &&
              ((tok_in.buttons & trig_r) == trig_r);
    if (fire) begin
      if (!tok_in.found || (prio_r > tok_in.best)) begin
        tok_nxt.found   = 1'b1;
        tok_nxt.amb     = 1'b0;
        tok_nxt.best    = prio_r;
        tok_nxt.sel     = IDX_W'(CellIdx);
        tok_nxt.win_act = act_r;
      end else if (prio_r == tok_in.best) begin
        tok_nxt.amb = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      en_r    <= 1'b0;
    end else if (advance) begin
      valid_r <= tok_in.valid;
      if (hit) begin
        en_r <= tok_in.en;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      data_r <= tok_nxt;
      if (hit) begin
        trig_r <= tok_in.trig;
        prio_r <= tok_in.prio;
        act_r  <= tok_in.wr_act;
      end
    end
  end

  always_comb begin
    tok_out       = data_r;
    tok_out.valid = valid_r;
  end

endmodule

>>> hdl/pbr_out.sv
// Result stage: turns the winning rule into status and coordinates, holds the output register.
module pbr_out
  import pbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  token_t                tok,
  input  cfg_t                  cfg,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  advance
);

  logic              out_valid_r;
  result_t           res_r;
  result_t           res_nxt;
  logic [MASK_W-1:0] stray;
  logic [COORD_W-1:0] dir_x;

  assign advance = !out_valid_r || out_tready;
  assign stray   = tok.win_act.outs & ~cfg.known_mask;

  always_comb begin
    case (tok.key) inside
      8'd1, 8'd4, 8'd7: dir_x = cfg.custom_en ? cfg.custom_l : cfg.default_l;
      8'd3, 8'd6, 8'd9: dir_x = cfg.custom_en ? cfg.custom_r : cfg.default_r;
      default:          dir_x = cfg.custom_en ? cfg.custom_n : cfg.default_n;
    endcase
  end

  always_comb begin
    res_nxt         = '0;
    res_nxt.status  = ST_NO_MATCH;
    if (tok.found) begin
      res_nxt.matched = 1'b1;
      res_nxt.sel     = tok.sel;
      if (tok.amb) begin
        res_nxt.status = ST_AMBIGUOUS;
        res_nxt.detail = MASK_W'(tok.best);
      end else begin
        res_nxt.bits = tok.win_act.outs & cfg.known_mask;
        if (stray != '0) begin
          res_nxt.status = ST_BAD_OUTPUTS;
          res_nxt.detail = stray;
        end else begin
          case (tok.win_act.form)
            FORM_FIXED: begin
              res_nxt.status = ST_RESOLVED;
              res_nxt.x      = tok.win_act.fixed_xy[COORD_W-1:0];
              res_nxt.y      = tok.win_act.fixed_xy[MASK_W-1:COORD_W];
            end
            FORM_DIR: begin
              if (!tok.win_act.needs_dir) begin
                res_nxt.status = ST_BAD_POLICY;
              end else if ((tok.key == '0) || (tok.key > 8'd9)) begin
                res_nxt.status = ST_BAD_KEY;
                res_nxt.detail = MASK_W'(tok.key);
              end else begin
                res_nxt.status = ST_RESOLVED;
                res_nxt.x      = dir_x;
                res_nxt.y      = tok.win_act.forced_y;
              end
            end
            default: begin
              res_nxt.status = ST_BAD_FORM;
              res_nxt.detail = MASK_W'(tok.win_act.form);
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tok.valid && !tok.wr;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_r};

endmodule

>>> hdl/priority_button_rule_resolver.sv
// Top level: rule cell chain, configuration registers and result stage.
// Each transaction is registered in every rule cell in turn, then in the output register.
// Throughput: one transaction per cycle; the whole cell chain advances in lockstep
// and stalls only while a result waits in the output register.
// Rule writes travel the chain and update their cell in order; they give no result.
// Reset (rst_n, synchronous): all rules disabled, chain and output empty, registers to defaults.
module priority_button_rule_resolver
  import pbr_pkg::*;
#(
  parameter int NUM_RULES = NUM_RULES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rule_index, rule_enabled, rule_trigger_mask, rule_priority, rule_form,
  // rule_fixed_xy, rule_needs_direction_x, rule_forced_y, rule_outputs,
  // button_mask, stick_dir, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [0:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // status, matched, selected_index, output_bits, stick_x, stick_y, detail, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg_r;
  token_t tok [NUM_RULES+1];
  logic   advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.custom_en  <= 1'b0;
      cfg_r.custom_l   <= 8'd0;
      cfg_r.custom_n   <= 8'd128;
      cfg_r.custom_r   <= 8'd255;
      cfg_r.default_l  <= 8'd0;
      cfg_r.default_n  <= 8'd128;
      cfg_r.default_r  <= 8'd255;
      cfg_r.known_mask <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUSTOM_EN:  cfg_r.custom_en  <= cfg_wdata[0];
        REG_CUSTOM_L:   cfg_r.custom_l   <= cfg_wdata[COORD_W-1:0];
        REG_CUSTOM_N:   cfg_r.custom_n   <= cfg_wdata[COORD_W-1:0];
        REG_CUSTOM_R:   cfg_r.custom_r   <= cfg_wdata[COORD_W-1:0];
        REG_DEFAULT_L:  cfg_r.default_l  <= cfg_wdata[COORD_W-1:0];
        REG_DEFAULT_N:  cfg_r.default_n  <= cfg_wdata[COORD_W-1:0];
        REG_DEFAULT_R:  cfg_r.default_r  <= cfg_wdata[COORD_W-1:0];
        REG_KNOWN_MASK: cfg_r.known_mask <= cfg_wdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_tready = advance;

  always_comb begin
    tok[0]                  = '0;
    tok[0].valid            = in_tvalid;
    tok[0].wr               = in_tuser[0];
    tok[0].index            = in_tdata[2:0];
    tok[0].en               = in_tdata[3];
    tok[0].trig             = in_tdata[19:4];
    tok[0].prio             = in_tdata[27:20];
    tok[0].wr_act.form      = in_tdata[29:28];
    tok[0].wr_act.fixed_xy  = in_tdata[45:30];
    tok[0].wr_act.needs_dir = in_tdata[46];
    tok[0].wr_act.forced_y  = in_tdata[54:47];
    tok[0].wr_act.outs      = in_tdata[70:55];
    tok[0].buttons          = in_tdata[86:71];
    tok[0].key              = in_tdata[94:87];
  end

  for (genvar g = 0; g < NUM_RULES; g++) begin : g_cell
    pbr_cell #(
      .CellIdx(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  pbr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .tok        (tok[NUM_RULES]),
    .cfg        (cfg_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .advance    (advance)
  );

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    tok[NUM_RULES].valid && tok[NUM_RULES].wr && advance |=> !out_tvalid)
    else $error("rule write produced a result");

  a_resolved_matched: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_RESOLVED) |-> out_tdata[3])
    else $error("resolved result without a match");

  a_no_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] == ST_NO_MATCH) |->
      (out_tdata[54:4] == '0))
    else $error("no-match result carries data");

  a_empty_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

endmodule

>>> verif/tb_priority_button_rule_resolver.sv
// Testbench for the priority button rule resolver: rule table predictor and stream checks.
`timescale 1ns / 100ps

module tb_priority_button_rule_resolver;
  import pbr_pkg::*;

  localparam logic OP_RESOLVE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  localparam logic [FORM_W-1:0] FORM_ODD_2 = 2'd2;
  localparam logic [FORM_W-1:0] FORM_ODD_3 = 2'd3;

  localparam int SETTLE_CYCLES    = 24;
  localparam int RANDOM_PHASES    = 6;
  localparam int PHASE_ITEMS      = 305;
  localparam int LONG_HOLD_AT     = 300;
  localparam int LONG_HOLD_CYCLES = 150;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   idx;
    logic               en;
    logic [MASK_W-1:0]  trig;
    logic [PRIO_W-1:0]  prio;
    logic [FORM_W-1:0]  form;
    logic [MASK_W-1:0]  fixed_xy;
    logic               needs;
    logic [COORD_W-1:0] forced_y;
    logic [MASK_W-1:0]  outs;
    logic [MASK_W-1:0]  buttons;
    logic [KEY_W-1:0]   key;
  } rule_req_t;

  typedef struct packed {
    logic              en;
    logic [MASK_W-1:0] trig;
    logic [PRIO_W-1:0] prio;
  } rule_match_t;

  class override_ledger;
    rule_match_t rule_tbl[NUM_RULES_DEF];
    action_t     actions[NUM_RULES_DEF];
    cfg_t        regs;
    result_t     expected_overrides[$];
    int          errors;

    function new();
      foreach (rule_tbl[i]) begin
        rule_tbl[i] = '0;
        actions[i] = '0;
      end
      regs.custom_en  = 1'b0;
      regs.custom_l   = 8'd0;
      regs.custom_n   = 8'd128;
      regs.custom_r   = 8'd255;
      regs.default_l  = 8'd0;
      regs.default_n  = 8'd128;
      regs.default_r  = 8'd255;
      regs.known_mask = 16'hFFFF;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_CUSTOM_EN:  regs.custom_en  = v[0];
        REG_CUSTOM_L:   regs.custom_l   = v[COORD_W-1:0];
        REG_CUSTOM_N:   regs.custom_n   = v[COORD_W-1:0];
        REG_CUSTOM_R:   regs.custom_r   = v[COORD_W-1:0];
        REG_DEFAULT_L:  regs.default_l  = v[COORD_W-1:0];
        REG_DEFAULT_N:  regs.default_n  = v[COORD_W-1:0];
        REG_DEFAULT_R:  regs.default_r  = v[COORD_W-1:0];
        REG_KNOWN_MASK: regs.known_mask = v;
        default: ;
      endcase
    endfunction

    function void predict_override(rule_req_t r);
      logic              found, amb;
      logic [PRIO_W-1:0] best;
      logic [IDX_W-1:0]  sel;
      logic [MASK_W-1:0] stray;
      action_t           a;
      result_t           res;
      int                col;
      if (r.op == OP_WRITE) begin
        if (r.idx < NUM_RULES_DEF) begin
          rule_tbl[r.idx] = '{en: r.en, trig: r.trig, prio: r.prio};
          actions[r.idx] = '{outs: r.outs, form: r.form, fixed_xy: r.fixed_xy,
                             needs_dir: r.needs, forced_y: r.forced_y};
        end
        return;
      end
      found = 1'b0;
      amb   = 1'b0;
      best  = '0;
      sel   = '0;
      for (int i = 0; i < NUM_RULES_DEF; i++) begin
        if (!rule_tbl[i].en || rule_tbl[i].trig == '0 ||
            (r.buttons & rule_tbl[i].trig) != rule_tbl[i].trig)
          continue;
        if (!found || rule_tbl[i].prio > best) begin
          found = 1'b1;
          amb   = 1'b0;
          best  = rule_tbl[i].prio;
          sel   = i[IDX_W-1:0];
        end else if (rule_tbl[i].prio == best) begin
          amb = 1'b1;
        end
      end
      res = '0;
      res.status = ST_NO_MATCH;
      if (found && amb) begin
        res.status  = ST_AMBIGUOUS;
        res.matched = 1'b1;
        res.sel     = sel;
        res.detail  = {8'd0, best};
      end else if (found) begin
        a = actions[sel];
        res.matched = 1'b1;
        res.sel     = sel;
        res.bits    = a.outs & regs.known_mask;
        stray       = a.outs & ~regs.known_mask;
        if (stray != '0) begin
          res.status = ST_BAD_OUTPUTS;
          res.detail = stray;
        end else if (a.form == FORM_FIXED) begin
          res.status = ST_RESOLVED;
          res.x      = a.fixed_xy[7:0];
          res.y      = a.fixed_xy[15:8];
        end else if (a.form == FORM_DIR) begin
          if (!a.needs_dir) begin
            res.status = ST_BAD_POLICY;
          end else if (r.key < 1 || r.key > 9) begin
            res.status = ST_BAD_KEY;
            res.detail = {8'd0, r.key};
          end else begin
            res.status = ST_RESOLVED;
            res.y      = a.forced_y;
            col        = (int'(r.key) - 1) % 3;
            if (col == 0)
              res.x = regs.custom_en ? regs.custom_l : regs.default_l;
            else if (col == 2)
              res.x = regs.custom_en ? regs.custom_r : regs.default_r;
            else
              res.x = regs.custom_en ? regs.custom_n : regs.default_n;
          end
        end else begin
          res.status = ST_BAD_FORM;
          res.detail = {14'd0, a.form};
        end
      end
      expected_overrides.push_back(res);
    endfunction

    function void match_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_override(logic [OUT_DATA_W-1:0] d);
      result_t want;
      if (expected_overrides.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h", $time, d);
        errors++;
        return;
      end
      want = expected_overrides.pop_front();
      match_field("status",         want.status,  d[2:0]);
      match_field("matched",        want.matched, d[3]);
      match_field("selected_index", want.sel,     d[6:4]);
      match_field("output_bits",    want.bits,    d[22:7]);
      match_field("stick_x",        want.x,       d[30:23]);
      match_field("stick_y",        want.y,       d[38:31]);
      match_field("detail",         want.detail,  d[54:39]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [0:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  override_ledger ledger = new();
  int             send_calm;

  priority_button_rule_resolver #(
    .NUM_RULES(NUM_RULES_DEF)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // at least half the draws idle-free, plus occasional calm stretches
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic rule_req_t rule_write(logic [IDX_W-1:0] idx, logic en,
                                           logic [MASK_W-1:0] trig, logic [PRIO_W-1:0] prio,
                                           logic [FORM_W-1:0] form, logic [MASK_W-1:0] fixed_xy,
                                           logic needs, logic [COORD_W-1:0] forced_y,
                                           logic [MASK_W-1:0] outs);
    rule_req_t r;
    r = '0;
    r.op = OP_WRITE;
    r.idx = idx;
    r.en = en;
    r.trig = trig;
    r.prio = prio;
    r.form = form;
    r.fixed_xy = fixed_xy;
    r.needs = needs;
    r.forced_y = forced_y;
    r.outs = outs;
    return r;
  endfunction

  function automatic rule_req_t resolve_req(logic [MASK_W-1:0] buttons, logic [KEY_W-1:0] key);
    rule_req_t r;
    r = '0;
    r.op = OP_RESOLVE;
    r.buttons = buttons;
    r.key = key;
    return r;
  endfunction

  task automatic send_item(rule_req_t r);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {1'b0, r.key, r.buttons, r.outs, r.forced_y, r.needs, r.fixed_xy,
                  r.form, r.prio, r.trig, r.en, r.idx};
    do @(posedge clk); while (!in_tready);
    ledger.predict_override(r);
  endtask

  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (ledger.expected_overrides.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx[8];
    logic [CFG_DATA_W-1:0] val[8];
    idx = '{REG_CUSTOM_EN, REG_CUSTOM_L, REG_CUSTOM_N, REG_CUSTOM_R,
            REG_DEFAULT_L, REG_DEFAULT_N, REG_DEFAULT_R, REG_KNOWN_MASK};
    val = '{{15'd0, c.custom_en}, {8'd0, c.custom_l}, {8'd0, c.custom_n},
            {8'd0, c.custom_r}, {8'd0, c.default_l}, {8'd0, c.default_n},
            {8'd0, c.default_r}, c.known_mask};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      ledger.set_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_random_phase(int n);
    rule_req_t r;
    int        a, b;
    for (int k = 0; k < n; k++) begin
      // don't-care fields stay random on both kinds of transaction
      r.op       = ($urandom_range(0, 99) < 30) ? OP_WRITE : OP_RESOLVE;
      r.idx      = IDX_W'($urandom_range(0, NUM_RULES_DEF - 1));
      r.en       = ($urandom_range(0, 9) != 0);
      a          = $urandom_range(0, MASK_W - 1);
      b          = $urandom_range(0, MASK_W - 1);
      case ($urandom_range(0, 9))
        0:       r.trig = '0;
        1:       r.trig = MASK_W'($urandom);
        default: r.trig = (16'd1 << a) | (16'd1 << b);
      endcase
      r.prio     = PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                : $urandom_range(0, 255));
      a          = $urandom_range(0, 9);
      if (a < 6)
        r.form = FORM_DIR;
      else if (a < 8)
        r.form = FORM_FIXED;
      else
        r.form = $urandom_range(0, 1) ? FORM_ODD_2 : FORM_ODD_3;
      r.fixed_xy = MASK_W'($urandom);
      r.needs    = ($urandom_range(0, 7) != 0);
      r.forced_y = COORD_W'($urandom);
      r.outs     = MASK_W'($urandom);
      if ($urandom_range(0, 9) < 6)
        r.outs = r.outs & ledger.regs.known_mask;
      case ($urandom_range(0, 9))
        0:       r.buttons = '0;
        1:       r.buttons = '1;
        2:       r.buttons = MASK_W'($urandom);
        default: r.buttons = MASK_W'($urandom | $urandom);
      endcase
      r.key      = KEY_W'(($urandom_range(0, 4) != 0) ? $urandom_range(1, 9)
                                                      : $urandom_range(0, 255));
      send_item(r);
      if (k == n / 2)
        wait_quiet();
    end
  endtask

  initial begin : result_drain
    int gap, calm, results_seen;
    logic long_hold_done;
    out_tready <= 1'b0;
    gap = 0;
    calm = 0;
    results_seen = 0;
    long_hold_done = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_tready && out_tvalid) begin
        ledger.check_override(out_tdata);
        results_seen++;
        gap = draw_gap(calm);
        if (results_seen >= LONG_HOLD_AT && !long_hold_done) begin
          gap = LONG_HOLD_CYCLES;
          long_hold_done = 1'b1;
        end
        if (gap != 0)
          out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (gap > 0)
          gap--;
        if (gap == 0)
          out_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    cfg_t        c;
    logic [95:0] rnd;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_RESOLVE;
    cfg_we    <= 1'b0;
    cfg_index <= REG_CUSTOM_EN;
    cfg_wdata <= '0;
    send_calm = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    c = '{custom_en: 1'b0, custom_l: 8'd0, custom_n: 8'd128, custom_r: 8'd255,
          default_l: 8'd0, default_n: 8'd128, default_r: 8'd255, known_mask: 16'h7FFF};
    program_settings(c);

    send_item(resolve_req(16'h0000, 8'd5));            // empty table
    send_item(rule_write(3'd0, 1'b1, 16'h0001, 8'd5, FORM_FIXED, 16'hFF00, 1'b0, 8'd0, 16'h00FF));
    send_item(resolve_req(16'h0001, 8'd5));
    send_item(rule_write(3'd1, 1'b1, 16'h0000, 8'd255, FORM_FIXED, 16'h1234, 1'b0, 8'd0, 16'h0));
    send_item(resolve_req(16'hFFFF, 8'd0));            // zero trigger never fires
    send_item(rule_write(3'd2, 1'b1, 16'h8000, 8'd5, FORM_DIR, 16'h0, 1'b1, 8'hFF, 16'h0001));
    send_item(resolve_req(16'h8001, 8'd5));            // tie at top
    send_item(rule_write(3'd3, 1'b1, 16'h8001, 8'd200, FORM_DIR, 16'h0, 1'b0, 8'h40, 16'h0002));
    send_item(resolve_req(16'h8001, 8'd5));            // missing direction policy
    send_item(rule_write(3'd3, 1'b1, 16'h8001, 8'd200, FORM_DIR, 16'h0, 1'b1, 8'h40, 16'h0002));
    send_item(resolve_req(16'h8001, 8'd0));
    send_item(resolve_req(16'h8001, 8'd10));
    send_item(resolve_req(16'h8001, 8'd255));
    send_item(resolve_req(16'h8001, 8'd1));
    send_item(resolve_req(16'h8001, 8'd5));
    send_item(resolve_req(16'h8001, 8'd9));
    send_item(rule_write(3'd4, 1'b1, 16'h0002, 8'd255, FORM_ODD_2, 16'h0, 1'b1, 8'd0, 16'h0));
    send_item(resolve_req(16'h0002, 8'd3));
    send_item(rule_write(3'd4, 1'b1, 16'h0002, 8'd255, FORM_ODD_3, 16'h0, 1'b1, 8'd0, 16'h0));
    send_item(resolve_req(16'h0002, 8'd3));
    send_item(rule_write(3'd7, 1'b0, 16'h0004, 8'd255, FORM_FIXED, 16'h5555, 1'b0, 8'd0, 16'h0));
    send_item(resolve_req(16'h0004, 8'd5));            // disabled rule
    send_item(rule_write(3'd5, 1'b1, 16'h0008, 8'd0, FORM_FIXED, 16'hAAAA, 1'b0, 8'd0, 16'hFFFF));
    send_item(resolve_req(16'h0008, 8'd5));            // stray output bit ahead of form

    for (int ph = 1; ph <= RANDOM_PHASES; ph++) begin
      wait_quiet();
      rnd = {$urandom, $urandom, $urandom};
      c = rnd[$bits(cfg_t)-1:0];
      if ($urandom_range(0, 1))
        c.known_mask = 16'hFFFF;
      case (ph)
        1: begin
          c.custom_en = 1'b1;
          c.custom_l = 8'd255;
          c.custom_n = 8'd0;
          c.custom_r = 8'd255;
          c.known_mask = 16'hFFFF;
        end
        2: begin
          c.custom_en = 1'b0;
          c.default_l = 8'd255;
          c.default_n = 8'd0;
          c.default_r = 8'd0;
          c.known_mask = 16'h0000;
        end
        default: ;
      endcase
      program_settings(c);
      run_random_phase(PHASE_ITEMS);
    end

    in_tvalid <= 1'b0;
    while (ledger.expected_overrides.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_overrides.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> priority_button_rule_resolver.f
hdl/pbr_pkg.sv
hdl/pbr_cell.sv
hdl/pbr_out.sv
hdl/priority_button_rule_resolver.sv
verif/tb_priority_button_rule_resolver.sv
